@@ sv/spq_pkg.sv @@
`default_nettype none
package spq_pkg;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned KEY_BITS     = 32;
  localparam int unsigned PAYLOAD_BITS = 32;
  localparam int unsigned COUNT_BITS   = 5;
  localparam int unsigned LIMIT_BITS   = 5;

  localparam logic [1:0] OP_OFFER = 2'd0;
  localparam logic [1:0] OP_POLL  = 2'd1;
  localparam logic [1:0] OP_PEEK  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]              opcode;
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [KEY_BITS-1:0]     out_key;
    logic [PAYLOAD_BITS-1:0] out_payload;
    logic [COUNT_BITS-1:0]   count;
  } out_item_t;

  typedef struct packed {
    logic insert;
    logic remove;
    logic occupied;
    logic at_tail;
  } cell_ctrl_t;

endpackage
`default_nettype wire

@@ sv/sorted_priority_queue_top.sv @@
`default_nettype none
// Bounded priority queue of DEPTH entries held in a chain of cells in ascending key order,
// with the least entry in the first cell. Every operation compares the offered key against
// all cells at once and shifts the chain by at most one place, so one operation is taken
// per clock cycle and its single result appears in the cycle after the transfer; the only
// limit on rate is the output register, which holds a result while the output is stalled.
// Equal keys leave in arrival order. The capacity limit register (0 or above DEPTH meaning
// DEPTH) should be written only while the queue is idle.
module sorted_priority_queue_top
  import spq_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire in_item_t              in_item_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_item_t                  out_item_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [LIMIT_BITS-1:0] cfg_wdata_i
);

  logic [LIMIT_BITS-1:0] limit_q;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  out_valid_q;
  out_item_t             out_item_q, out_item_d;

  logic [LIMIT_BITS-1:0] limit_eff;
  logic                  accept, full, empty, do_insert, do_remove;

  logic                    cell_gt      [DEPTH];
  logic [KEY_BITS-1:0]     cell_key     [DEPTH];
  logic [PAYLOAD_BITS-1:0] cell_payload [DEPTH];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign limit_eff = ((limit_q == '0) || (limit_q > LIMIT_BITS'(DEPTH))) ?
                     LIMIT_BITS'(DEPTH) : limit_q;
  assign full      = (count_q >= limit_eff);
  assign empty     = (count_q == '0);
  assign do_insert = accept && (in_item_i.opcode == OP_OFFER) && !full;
  assign do_remove = accept && (in_item_i.opcode == OP_POLL) && !empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctrl_t              ctrl;
    logic                    left_gt;
    logic [KEY_BITS-1:0]     left_key, right_key;
    logic [PAYLOAD_BITS-1:0] left_payload, right_payload;

    assign ctrl.insert   = do_insert;
    assign ctrl.remove   = do_remove;
    assign ctrl.occupied = (COUNT_BITS'(i) < count_q);
    assign ctrl.at_tail  = (COUNT_BITS'(i) == count_q);

    if (i == 0) begin : g_first
      assign left_gt      = 1'b0;
      assign left_key     = in_item_i.key;
      assign left_payload = in_item_i.payload;
    end else begin : g_inner
      assign left_gt      = cell_gt[i-1];
      assign left_key     = cell_key[i-1];
      assign left_payload = cell_payload[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_key     = cell_key[i];
      assign right_payload = cell_payload[i];
    end else begin : g_body
      assign right_key     = cell_key[i+1];
      assign right_payload = cell_payload[i+1];
    end

    spq_cell u_cell (
      .clk_i          (clk_i),
      .ctrl_i         (ctrl),
      .new_key_i      (in_item_i.key),
      .new_payload_i  (in_item_i.payload),
      .left_gt_i      (left_gt),
      .left_key_i     (left_key),
      .left_payload_i (left_payload),
      .right_key_i    (right_key),
      .right_payload_i(right_payload),
      .gt_o           (cell_gt[i]),
      .key_o          (cell_key[i]),
      .payload_o      (cell_payload[i])
    );
  end

  always_comb begin
    count_d                = count_q;
    out_item_d.status      = ST_DONE;
    out_item_d.out_key     = '0;
    out_item_d.out_payload = '0;
    case (in_item_i.opcode)
      OP_OFFER: begin
        if (full) begin
          out_item_d.status = ST_FULL;
        end else begin
          count_d = count_q + COUNT_BITS'(1);
        end
      end
      OP_POLL, OP_PEEK: begin
        if (empty) begin
          out_item_d.status = ST_EMPTY;
        end else begin
          out_item_d.out_key     = cell_key[0];
          out_item_d.out_payload = cell_payload[0];
          if (in_item_i.opcode == OP_POLL) begin
            count_d = count_q - COUNT_BITS'(1);
          end
        end
      end
      OP_CLEAR: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
    out_item_d.count = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
`default_nettype wire

@@ sv/spq_cell.sv @@
`default_nettype none
module spq_cell
  import spq_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire cell_ctrl_t              ctrl_i,
  input  wire logic [KEY_BITS-1:0]     new_key_i,
  input  wire logic [PAYLOAD_BITS-1:0] new_payload_i,
  input  wire logic                    left_gt_i,
  input  wire logic [KEY_BITS-1:0]     left_key_i,
  input  wire logic [PAYLOAD_BITS-1:0] left_payload_i,
  input  wire logic [KEY_BITS-1:0]     right_key_i,
  input  wire logic [PAYLOAD_BITS-1:0] right_payload_i,
  output logic                         gt_o,
  output logic [KEY_BITS-1:0]          key_o,
  output logic [PAYLOAD_BITS-1:0]      payload_o
);

  logic [KEY_BITS-1:0]     key_q, key_d;
  logic [PAYLOAD_BITS-1:0] payload_q, payload_d;

  assign gt_o = ctrl_i.occupied && (key_q > new_key_i);

  // On insertion the entries greater than the new key move one cell towards the tail,
  // and the first such cell, or the tail cell, takes the new entry.
  always_comb begin
    key_d     = key_q;
    payload_d = payload_q;
    if (ctrl_i.insert) begin
      if (left_gt_i) begin
        key_d     = left_key_i;
        payload_d = left_payload_i;
      end else if (gt_o || ctrl_i.at_tail) begin
        key_d     = new_key_i;
        payload_d = new_payload_i;
      end
    end else if (ctrl_i.remove) begin
      key_d     = right_key_i;
      payload_d = right_payload_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    payload_q <= payload_d;
  end

  assign key_o     = key_q;
  assign payload_o = payload_q;

endmodule
`default_nettype wire

@@ verif/tb_sorted_priority_queue_top.sv @@
`default_nettype none
module tb_sorted_priority_queue_top;
  import spq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [KEY_BITS-1:0] KEY_MAX = 32'hFFFF_FFFF;
  localparam logic [PAYLOAD_BITS-1:0] PAY_MAX = 32'hFFFF_FFFF;

  class queue_order_checker;
    logic [KEY_BITS-1:0]     sorted_keys[DEPTH];
    logic [PAYLOAD_BITS-1:0] sorted_payloads[DEPTH];
    int unsigned             stored_count;
    logic [LIMIT_BITS-1:0]   limit_reg;
    out_item_t               pending_results[$];
    int unsigned             errors;
    int unsigned             checked;

    function new();
      stored_count = 0;
      limit_reg    = '0;
      errors       = 0;
      checked      = 0;
    endfunction

    function void set_limit(logic [LIMIT_BITS-1:0] value);
      limit_reg = value;
    endfunction

    function int unsigned active_limit();
      if (limit_reg == 0 || limit_reg > DEPTH) begin
        return DEPTH;
      end
      return limit_reg;
    endfunction

    function void note_request(in_item_t req);
      out_item_t   res;
      int unsigned pos;
      res = '0;
      case (req.opcode)
        OP_OFFER: begin
          if (stored_count >= active_limit()) begin
            res.status = ST_FULL;
          end else begin
            pos = 0;
            while (pos < stored_count && sorted_keys[pos] <= req.key) begin
              pos++;
            end
            for (int unsigned i = stored_count; i > pos; i--) begin
              sorted_keys[i]     = sorted_keys[i-1];
              sorted_payloads[i] = sorted_payloads[i-1];
            end
            sorted_keys[pos]     = req.key;
            sorted_payloads[pos] = req.payload;
            stored_count++;
          end
        end
        OP_POLL, OP_PEEK: begin
          if (stored_count == 0) begin
            res.status = ST_EMPTY;
          end else begin
            res.out_key     = sorted_keys[0];
            res.out_payload = sorted_payloads[0];
            if (req.opcode == OP_POLL) begin
              for (int unsigned i = 1; i < stored_count; i++) begin
                sorted_keys[i-1]     = sorted_keys[i];
                sorted_payloads[i-1] = sorted_payloads[i];
              end
              stored_count--;
            end
          end
        end
        default: begin
          stored_count = 0;
        end
      endcase
      res.count = stored_count[COUNT_BITS-1:0];
      pending_results.push_back(res);
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at result %0d: %s", checked, what);
      errors++;
    endtask

    task check_response(out_item_t got);
      out_item_t exp;
      if (pending_results.size() == 0) begin
        report_mismatch("result arrived with nothing outstanding");
      end else begin
        exp = pending_results.pop_front();
        if (got.status !== exp.status) begin
          report_mismatch($sformatf("status %0d, expected %0d", got.status, exp.status));
        end
        if (got.out_key !== exp.out_key) begin
          report_mismatch($sformatf("key %h, expected %h", got.out_key, exp.out_key));
        end
        if (got.out_payload !== exp.out_payload) begin
          report_mismatch($sformatf("payload %h, expected %h",
                                    got.out_payload, exp.out_payload));
        end
        if (got.count !== exp.count) begin
          report_mismatch($sformatf("count %0d, expected %0d", got.count, exp.count));
        end
      end
      checked++;
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_item_t              in_item_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_item_t             out_item_o;
  logic                  cfg_we_i;
  logic [LIMIT_BITS-1:0] cfg_wdata_i;

  queue_order_checker order_chk;
  int unsigned        cycle_count;
  int unsigned        hold_left;
  bit                 calm;

  sorted_priority_queue_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // The receiver samples the output at each edge and then chooses its stall for the next.
  initial begin
    int unsigned burst_left;
    burst_left  = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        order_chk.check_response(out_item_o);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < 15) begin
        burst_left  = $urandom_range(0, 12);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic in_item_t make_op(logic [1:0] op, logic [KEY_BITS-1:0] key,
                                       logic [PAYLOAD_BITS-1:0] payload);
    in_item_t it;
    it.opcode  = op;
    it.key     = key;
    it.payload = payload;
    return it;
  endfunction

  function automatic in_item_t random_op(int offer_pct, int clear_pct);
    int               roll;
    logic [1:0]       op;
    logic [KEY_BITS-1:0] key;
    roll = $urandom_range(0, 99);
    if (roll < offer_pct) begin
      op = OP_OFFER;
    end else if (roll < offer_pct + clear_pct) begin
      op = OP_CLEAR;
    end else if ($urandom_range(0, 2) == 0) begin
      op = OP_PEEK;
    end else begin
      op = OP_POLL;
    end
    case ($urandom_range(0, 9))
      0:          key = '0;
      1:          key = KEY_MAX;
      2, 3, 4, 5: key = $urandom_range(0, 7);
      default:    key = $urandom;
    endcase
    return make_op(op, key, $urandom);
  endfunction

  task automatic send_op(in_item_t it);
    if (!calm && $urandom_range(0, 99) < 12) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    order_chk.note_request(it);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (order_chk.pending_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [LIMIT_BITS-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    order_chk.set_limit(value);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic run_phase(logic [LIMIT_BITS-1:0] lim, int n, int offer_pct, int clear_pct);
    write_limit(lim);
    repeat (n) send_op(random_op(offer_pct, clear_pct));
    drain();
  endtask

  initial begin
    order_chk   = new();
    hold_left   = 0;
    calm        = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  <= 1'b0;
    in_item_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty queue, extreme keys, equal keys leaving in arrival order, then a clear.
    send_op(make_op(OP_POLL, KEY_MAX, PAY_MAX));
    send_op(make_op(OP_PEEK, '0, '0));
    send_op(make_op(OP_OFFER, 32'd5, 32'hAAAA_5555));
    send_op(make_op(OP_OFFER, '0, '0));
    send_op(make_op(OP_OFFER, KEY_MAX, PAY_MAX));
    send_op(make_op(OP_OFFER, 32'd5, 32'h5555_AAAA));
    send_op(make_op(OP_OFFER, 32'd5, 32'h0123_4567));
    send_op(make_op(OP_PEEK, '0, '0));
    send_op(make_op(OP_POLL, '0, '0));
    send_op(make_op(OP_POLL, '0, '0));
    send_op(make_op(OP_CLEAR, KEY_MAX, PAY_MAX));
    drain();

    // A small limit reached, then lowered below the number of stored entries.
    write_limit(5'd4);
    for (int i = 0; i < 5; i++) begin
      send_op(make_op(OP_OFFER, 32'd9 - i, 32'hC0DE_0000 + i));
    end
    drain();
    write_limit(5'd2);
    send_op(make_op(OP_OFFER, 32'd1, 32'hDEAD_BEEF));
    send_op(make_op(OP_POLL, '0, '0));
    send_op(make_op(OP_POLL, '0, '0));
    send_op(make_op(OP_POLL, '0, '0));
    drain();

    run_phase(5'd16, 60, 60, 2);
    run_phase(5'd1, 30, 50, 3);
    run_phase(5'd31, 60, 55, 3);
    hold_left = 80;
    run_phase(5'd16, 70, 70, 1);
    run_phase(5'd3, 40, 50, 3);
    run_phase(5'd0, 60, 55, 3);
    run_phase(5'd20, 60, 50, 3);
    calm = 1'b1;
    run_phase(5'd16, 70, 50, 3);
    repeat (5) @(posedge clk_i);

    if (order_chk.errors == 0 && order_chk.pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
